@@ hw/rtl/tcw_pkg.sv @@
// tcw_pkg: shared types and constants of the text console writer
// request and result payloads, cell layout, op and register codes
// no dependencies
package tcw_pkg;

  // request ops
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLANK_FG = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLANK_BG = 1'd1;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  // reset colors of blanked cells
  localparam logic [3:0] RESET_BLANK_FG = 4'd7;
  localparam logic [3:0] RESET_BLANK_BG = 4'd0;

  typedef struct packed {
    logic [3:0] bg;
    logic [3:0] fg;
    logic [7:0] code;
  } cell_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  char_code;
    logic [3:0]  foreground;
    logic [3:0]  background;
    logic [10:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [10:0] cursor_position;
    logic        scrolled;
    logic [7:0]  read_code;
    logic [3:0]  read_foreground;
    logic [3:0]  read_background;
  } out_item_t;

endpackage

@@ hw/rtl/text_console_writer_unit.sv @@
// text_console_writer_unit: top level of the text console writer
// holds the blank-color registers and the result output register
// depends on tcw_pkg, tcw_engine, tcw_cell_ram
//
// The console keeps COLUMNS x ROWS cells in a single synchronous RAM and
// serves one request at a time. After reset the block holds in_stall high
// while it sweeps the RAM to blank cells (code 0, foreground 7, background
// 0); configuration writes are taken during that time. A put that touches one
// cell, a newline that stays on screen and an ignored code are handled in the
// idle state, so they can follow each other every cycle while results are
// taken; a read waits in a read state as the RAM read data is registered.
// A clear sweeps the store with blank cells, and a put or newline at the end
// of the screen scrolls by moving the rows up through the RAM read and write
// ports and blanking the last row. Each request yields one result carrying
// the cursor, which moves into an output register once that is empty or
// draining; until then no new request is taken. Blank colors affect only
// later scrolls and clears.
module text_console_writer_unit #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  tcw_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output tcw_pkg::out_item_t                   out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tcw_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [3:0]                           cfg_data
);

  localparam int unsigned TOTAL = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(TOTAL);

  logic [3:0]          fg_r, fg_nxt, bg_r, bg_nxt;
  logic                out_valid_r, out_valid_nxt;
  tcw_pkg::out_item_t  out_data_r;
  logic                in_ready, res_valid, res_take;
  tcw_pkg::out_item_t  res_data;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  tcw_pkg::cell_t      mem_wdata, mem_rdata;

  assign cfg_ready = 1'b1;

  always_comb begin
    fg_nxt = fg_r;
    bg_nxt = bg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tcw_pkg::CFG_BLANK_FG: fg_nxt = cfg_data;
        tcw_pkg::CFG_BLANK_BG: bg_nxt = cfg_data;
        default: begin
          fg_nxt = fg_r;
        end
      endcase
    end
  end

  // result moves into the output register when that is empty or draining
  assign res_take      = res_valid && (!out_valid_r || !out_stall);
  assign out_valid_nxt = res_take || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r        <= tcw_pkg::RESET_BLANK_FG;
      bg_r        <= tcw_pkg::RESET_BLANK_BG;
      out_valid_r <= 1'b0;
    end else begin
      fg_r        <= fg_nxt;
      bg_r        <= bg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (res_take) begin
      out_data_r <= res_data;
    end
  end

  tcw_engine #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .blank_fg  (fg_r),
    .blank_bg  (bg_r),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_data  (res_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  tcw_cell_ram #(
    .DEPTH (TOTAL),
    .AW    (AW)
  ) u_cell_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_stall  = !in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/tcw_cell_ram.sv @@
// tcw_cell_ram: screen cell store, one write port and one read port
// read data registered; uses tcw_pkg::cell_t
module tcw_cell_ram #(
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned AW    = 11
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  tcw_pkg::cell_t  wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output tcw_pkg::cell_t  rdata
);

  tcw_pkg::cell_t mem [DEPTH];
  tcw_pkg::cell_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/tcw_engine.sv @@
// tcw_engine: request sequencer of the text console writer
// cursor tracking, single-cell writes, scroll/clear/init sweeps over the cell store
// depends on tcw_pkg; drives tcw_cell_ram through its ports
module tcw_engine #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25,
  parameter int unsigned TOTAL   = COLUMNS * ROWS,
  parameter int unsigned AW      = $clog2(TOTAL),
  parameter int unsigned CW      = $clog2(TOTAL + 1),
  parameter int unsigned COLW    = $clog2(COLUMNS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcw_pkg::in_item_t   in_data,
  input  logic [3:0]          blank_fg,
  input  logic [3:0]          blank_bg,
  output logic                res_valid,
  input  logic                res_take,
  output tcw_pkg::out_item_t  res_data,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output tcw_pkg::cell_t      mem_wdata,
  output logic                mem_re,
  output logic [AW-1:0]       mem_raddr,
  input  tcw_pkg::cell_t      mem_rdata
);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_SCROLL, S_FIN, S_CLEAR, S_READ
  } state_t;

  localparam logic [AW-1:0] LAST_IDX  = AW'(TOTAL - 1);
  localparam logic [AW-1:0] MOVE_END  = AW'(TOTAL - COLUMNS);
  localparam logic [CW-1:0] CUR_END   = CW'(TOTAL);
  localparam logic [CW-1:0] CUR_AFTER = CW'(TOTAL - COLUMNS + 1);

  state_t              state_r, state_nxt;
  logic [CW-1:0]       cursor_r, cursor_nxt;
  logic [COLW-1:0]     col_r, col_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic                pend_put_r, pend_put_nxt;
  tcw_pkg::cell_t      pend_cell_r, pend_cell_nxt;
  logic                rd_ok_r, rd_ok_nxt;
  tcw_pkg::out_item_t  res_r, res_nxt;
  logic                res_valid_r, res_valid_nxt;

  tcw_pkg::cell_t      blank_cell, init_cell, put_cell;
  logic                accept, at_end;
  logic [CW:0]         next_rd;

  function automatic tcw_pkg::out_item_t make_res(logic [CW-1:0] cur, logic scr,
                                                  tcw_pkg::cell_t c);
    tcw_pkg::out_item_t r;
    r.cursor_position = 11'(cur);
    r.scrolled        = scr;
    r.read_code       = c.code;
    r.read_foreground = c.fg;
    r.read_background = c.bg;
    return r;
  endfunction

  assign blank_cell = '{bg: blank_bg, fg: blank_fg, code: 8'd0};
  assign init_cell  = '{bg: tcw_pkg::RESET_BLANK_BG, fg: tcw_pkg::RESET_BLANK_FG, code: 8'd0};
  assign put_cell   = '{bg: in_data.background, fg: in_data.foreground,
                        code: in_data.char_code};

  // a pending result that leaves this cycle frees the slot for the next request
  assign in_ready = (state_r == S_IDLE) && (!res_valid_r || res_take);
  assign accept   = in_valid && in_ready;
  assign at_end   = (cursor_r == CUR_END);
  // scroll reads run one cell ahead of the writes
  assign next_rd  = (CW+1)'(idx_r) + (CW+1)'(COLUMNS + 1);

  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    col_nxt       = col_r;
    idx_nxt       = idx_r;
    pend_put_nxt  = pend_put_r;
    pend_cell_nxt = pend_cell_r;
    rd_ok_nxt     = rd_ok_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && !res_take;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = blank_cell;
    mem_re        = 1'b0;
    mem_raddr     = AW'(COLUMNS);

    unique case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = init_cell;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_data.op)
            tcw_pkg::OP_PUT: begin
              if (in_data.char_code == 8'd0) begin
                res_nxt       = make_res(cursor_r, 1'b0, '0);
                res_valid_nxt = 1'b1;
              end else if (at_end) begin
                // writing or breaking the line past the last cell scrolls first
                mem_re        = 1'b1;
                mem_raddr     = AW'(COLUMNS);
                idx_nxt       = '0;
                pend_put_nxt  = (in_data.char_code != tcw_pkg::NEWLINE_CODE);
                pend_cell_nxt = put_cell;
                state_nxt     = S_SCROLL;
              end else if (in_data.char_code == tcw_pkg::NEWLINE_CODE) begin
                cursor_nxt    = cursor_r + (CW'(COLUMNS) - CW'(col_r));
                col_nxt       = '0;
                res_nxt       = make_res(cursor_r + (CW'(COLUMNS) - CW'(col_r)), 1'b0, '0);
                res_valid_nxt = 1'b1;
              end else begin
                mem_we        = 1'b1;
                mem_waddr     = AW'(cursor_r);
                mem_wdata     = put_cell;
                cursor_nxt    = cursor_r + 1'b1;
                col_nxt       = (col_r == COLW'(COLUMNS - 1)) ? '0 : col_r + 1'b1;
                res_nxt       = make_res(cursor_r + 1'b1, 1'b0, '0);
                res_valid_nxt = 1'b1;
              end
            end
            tcw_pkg::OP_CLEAR: begin
              idx_nxt   = '0;
              state_nxt = S_CLEAR;
            end
            tcw_pkg::OP_READ: begin
              rd_ok_nxt = (32'(in_data.cell_index) < 32'(TOTAL));
              mem_re    = (32'(in_data.cell_index) < 32'(TOTAL));
              mem_raddr = AW'(in_data.cell_index);
              state_nxt = S_READ;
            end
            default: begin
              res_nxt       = make_res(cursor_r, 1'b0, '0);
              res_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SCROLL: begin
        mem_we    = 1'b1;
        mem_wdata = (idx_r < MOVE_END) ? mem_rdata : blank_cell;
        mem_re    = (next_rd < (CW+1)'(TOTAL));
        mem_raddr = AW'(next_rd);
        if (idx_r == LAST_IDX) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_FIN: begin
        if (pend_put_r) begin
          mem_we     = 1'b1;
          mem_waddr  = MOVE_END;
          mem_wdata  = pend_cell_r;
          cursor_nxt = CUR_AFTER;
          col_nxt    = COLW'(1);
          res_nxt    = make_res(CUR_AFTER, 1'b1, '0);
        end else begin
          cursor_nxt = CUR_END;
          col_nxt    = '0;
          res_nxt    = make_res(CUR_END, 1'b1, '0);
        end
        res_valid_nxt = 1'b1;
        idx_nxt       = '0;
        state_nxt     = S_IDLE;
      end
      S_CLEAR: begin
        mem_we = 1'b1;
        if (idx_r == LAST_IDX) begin
          cursor_nxt    = '0;
          col_nxt       = '0;
          idx_nxt       = '0;
          res_nxt       = make_res('0, 1'b0, '0);
          res_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_READ: begin
        res_nxt       = make_res(cursor_r, 1'b0, rd_ok_r ? mem_rdata : '0);
        res_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cursor_r    <= '0;
      col_r       <= '0;
      idx_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      col_r       <= col_nxt;
      idx_r       <= idx_nxt;
      res_valid_r <= res_valid_nxt;
    end
    pend_put_r  <= pend_put_nxt;
    pend_cell_r <= pend_cell_nxt;
    rd_ok_r     <= rd_ok_nxt;
    res_r       <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res_data  = res_r;

endmodule

@@ hw/rtl/tcw_checker.sv @@
// tcw_checker: port-level checks of text_console_writer_unit
// bound to the top level below; depends on tcw_pkg
module tcw_checker #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input tcw_pkg::out_item_t  out_data
);

  localparam logic [10:0] CUR_END   = 11'(COLUMNS * ROWS);
  localparam logic [10:0] CUR_AFTER = 11'(COLUMNS * ROWS - COLUMNS + 1);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // cursor never goes beyond the position past the last cell
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.cursor_position <= CUR_END)
    else $error("cursor out of range");

  // a scroll leaves the cursor at the end or just after the start of the last row
  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.scrolled |->
      (out_data.cursor_position == CUR_END) || (out_data.cursor_position == CUR_AFTER))
    else $error("scroll left cursor at unexpected cell");

  // the clearing sweep after reset holds off requests
  a_init_stall: assert property (@(posedge clk)
    $past(!rst_n) && rst_n |-> in_stall)
    else $error("request accepted during reset sweep");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind text_console_writer_unit tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ tb/tcw_console_checker.sv @@
// tcw_console_checker: watches the request, result and register channels of the
// console writer, predicts every result and compares it field by field
// depends on tcw_pkg
module tcw_console_checker #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  tcw_pkg::in_item_t               in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  tcw_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [3:0]                      cfg_data,
  input  logic                            run_done,
  output int                              outstanding,
  output int                              fail_count
);

  localparam int unsigned CELLS = COLUMNS * ROWS;

  tcw_pkg::cell_t     screen [CELLS];
  int unsigned        cursor;
  logic [3:0]         blank_fg;
  logic [3:0]         blank_bg;
  tcw_pkg::out_item_t expected_results [$];
  int                 mismatch_count;

  assign fail_count = mismatch_count + (run_done ? outstanding : 0);

  task automatic blank_screen();
    for (int unsigned i = 0; i < CELLS; i++) begin
      screen[i] = '{bg: blank_bg, fg: blank_fg, code: 8'd0};
    end
    cursor = 0;
  endtask

  // rows move up one, bottom row blanked, cursor follows
  task automatic scroll_screen();
    for (int unsigned i = 0; i < CELLS - COLUMNS; i++) begin
      screen[i] = screen[i + COLUMNS];
    end
    for (int unsigned i = CELLS - COLUMNS; i < CELLS; i++) begin
      screen[i] = '{bg: blank_bg, fg: blank_fg, code: 8'd0};
    end
    cursor = cursor - COLUMNS;
  endtask

  task automatic apply_request(input tcw_pkg::in_item_t req, output tcw_pkg::out_item_t res);
    int unsigned    next_pos;
    tcw_pkg::cell_t rd_cell;
    res = '0;
    case (req.op)
      tcw_pkg::OP_PUT: begin
        if (req.char_code == tcw_pkg::NEWLINE_CODE) begin
          next_pos = cursor + COLUMNS - (cursor % COLUMNS);
          if (next_pos > CELLS) begin
            scroll_screen();
            res.scrolled = 1'b1;
            next_pos = cursor + COLUMNS - (cursor % COLUMNS);
          end
          cursor = next_pos;
        end else if (req.char_code != 8'd0) begin
          if (cursor >= CELLS) begin
            scroll_screen();
            res.scrolled = 1'b1;
          end
          screen[cursor] = '{bg: req.background, fg: req.foreground, code: req.char_code};
          cursor++;
        end
      end
      tcw_pkg::OP_CLEAR: blank_screen();
      tcw_pkg::OP_READ: begin
        if (req.cell_index < CELLS) begin
          rd_cell = screen[req.cell_index];
          res.read_code       = rd_cell.code;
          res.read_foreground = rd_cell.fg;
          res.read_background = rd_cell.bg;
        end
      end
      default: ;
    endcase
    res.cursor_position = 11'(cursor);
  endtask

  always @(posedge clk) begin
    tcw_pkg::out_item_t exp_res;
    tcw_pkg::out_item_t new_res;
    if (!rst_n) begin
      blank_fg = tcw_pkg::RESET_BLANK_FG;
      blank_bg = tcw_pkg::RESET_BLANK_BG;
      blank_screen();
      expected_results.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tcw_pkg::CFG_BLANK_FG) blank_fg = cfg_data;
        else if (cfg_index == tcw_pkg::CFG_BLANK_BG) blank_bg = cfg_data;
      end
      // compare before queuing this edge's request: its result cannot leave yet
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected result: cursor %0d scrolled %0d code %0d fg %0d bg %0d",
                     out_data.cursor_position, out_data.scrolled, out_data.read_code,
                     out_data.read_foreground, out_data.read_background);
          end
        end else begin
          exp_res = expected_results.pop_front();
          if (out_data.cursor_position !== exp_res.cursor_position ||
              out_data.scrolled        !== exp_res.scrolled ||
              out_data.read_code       !== exp_res.read_code ||
              out_data.read_foreground !== exp_res.read_foreground ||
              out_data.read_background !== exp_res.read_background) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("result mismatch: expected cursor %0d scrolled %0d code %0d fg %0d bg %0d",
                       exp_res.cursor_position, exp_res.scrolled, exp_res.read_code,
                       exp_res.read_foreground, exp_res.read_background);
              $display("                 actual   cursor %0d scrolled %0d code %0d fg %0d bg %0d",
                       out_data.cursor_position, out_data.scrolled, out_data.read_code,
                       out_data.read_foreground, out_data.read_background);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        apply_request(in_data, new_res);
        expected_results.push_back(new_res);
      end
    end
    outstanding = expected_results.size();
  end

endmodule

@@ tb/tb_text_console_writer_unit.sv @@
// tb_text_console_writer_unit: drives requests and register writes into the
// console writer under random idling and gives the verdict
// depends on tcw_pkg, text_console_writer_unit, tcw_console_checker
module tb_text_console_writer_unit;

  localparam int unsigned COLUMNS     = 80;
  localparam int unsigned ROWS        = 25;
  localparam int unsigned CELLS       = COLUMNS * ROWS;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int          PHASE_ITEMS = 128;
  localparam int          CYCLE_LIMIT = 4_000_000;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  tcw_pkg::in_item_t               in_data;
  logic                            out_valid;
  logic                            out_stall;
  tcw_pkg::out_item_t              out_data;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [3:0]                      cfg_data;
  logic                            run_done;
  int                              outstanding;
  int                              fail_count;
  int                              send_idle_pct;
  int                              recv_idle_pct;
  int                              cycle_count;

  text_console_writer_unit #(.COLUMNS(COLUMNS), .ROWS(ROWS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  tcw_console_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .run_done(run_done),
    .outstanding(outstanding), .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic tcw_pkg::in_item_t make_request(input logic [1:0] op,
                                                     input logic [7:0] code,
                                                     input logic [3:0] fg,
                                                     input logic [3:0] bg,
                                                     input logic [10:0] idx);
    tcw_pkg::in_item_t req;
    req.op         = op;
    req.char_code  = code;
    req.foreground = fg;
    req.background = bg;
    req.cell_index = idx;
    return req;
  endfunction

  // mostly text and newlines so the screen fills and scrolls often
  function automatic tcw_pkg::in_item_t random_request();
    tcw_pkg::in_item_t req;
    int unsigned       pick;
    int unsigned       region;
    req  = make_request(2'($urandom_range(3)), 8'($urandom_range(255)),
                        4'($urandom_range(15)), 4'($urandom_range(15)),
                        11'($urandom_range(2047)));
    pick = $urandom_range(99);
    if (pick < 40) begin
      req.op        = tcw_pkg::OP_PUT;
      req.char_code = tcw_pkg::NEWLINE_CODE;
    end else if (pick < 78) begin
      req.op = tcw_pkg::OP_PUT;
      do req.char_code = 8'($urandom_range(255, 1));
      while (req.char_code == tcw_pkg::NEWLINE_CODE);
    end else if (pick < 81) begin
      req.op        = tcw_pkg::OP_PUT;
      req.char_code = 8'd0;
    end else if (pick < 83) begin
      req.op = tcw_pkg::OP_CLEAR;
    end else if (pick < 98) begin
      req.op = tcw_pkg::OP_READ;
      region = $urandom_range(9);
      if (region < 3) req.cell_index = 11'($urandom_range(CELLS - 1, CELLS - 2 * COLUMNS));
      else if (region < 8) req.cell_index = 11'($urandom_range(CELLS - 1));
      else req.cell_index = 11'($urandom_range(2047));
    end else begin
      req.op = OP_UNUSED;
    end
    return req;
  endfunction

  task automatic send_request(input tcw_pkg::in_item_t req);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
  endtask

  // the first edge lets the checker queue the request accepted just now
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_blank_colors(input logic [3:0] fg, input logic [3:0] bg);
    cfg_valid <= 1'b1;
    cfg_index <= tcw_pkg::CFG_BLANK_FG;
    cfg_data  <= fg;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= tcw_pkg::CFG_BLANK_BG;
    cfg_data  <= bg;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int send_pct [3];
    int recv_pct [3];
    send_pct = '{32, 54, 0};
    recv_pct = '{54, 32, 0};
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = tcw_pkg::CFG_BLANK_FG;
    cfg_data      = 4'd0;
    run_done      = 1'b0;
    cycle_count   = 0;
    send_idle_pct = send_pct[0];
    recv_idle_pct = recv_pct[0];
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // cells blanked at reset keep their colors after this write
    set_blank_colors(4'd0, 4'd15);
    send_request(make_request(tcw_pkg::OP_READ, 8'd0, 4'd0, 4'd0, 11'd0));
    send_request(make_request(tcw_pkg::OP_READ, 8'd0, 4'd0, 4'd0, 11'(CELLS - 1)));
    send_request(make_request(tcw_pkg::OP_READ, 8'd0, 4'd0, 4'd0, 11'(CELLS)));
    send_request(make_request(tcw_pkg::OP_READ, 8'hff, 4'hf, 4'hf, 11'h7ff));
    send_request(make_request(tcw_pkg::OP_PUT, 8'd0, 4'hf, 4'hf, 11'h7ff));
    send_request(make_request(OP_UNUSED, 8'hff, 4'hf, 4'hf, 11'h7ff));
    send_request(make_request(tcw_pkg::OP_PUT, 8'd65, 4'hf, 4'h0, 11'd0));
    send_request(make_request(tcw_pkg::OP_PUT, 8'hff, 4'h0, 4'hf, 11'd0));
    send_request(make_request(tcw_pkg::OP_PUT, 8'd1, 4'h5, 4'ha, 11'd0));
    send_request(make_request(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE, 4'h3, 4'hc, 11'd0));
    send_request(make_request(tcw_pkg::OP_READ, 8'd0, 4'd0, 4'd0, 11'd0));
    send_request(make_request(tcw_pkg::OP_READ, 8'd0, 4'd0, 4'd0, 11'd1));
    send_request(make_request(tcw_pkg::OP_READ, 8'd0, 4'd0, 4'd0, 11'd2));
    send_request(make_request(tcw_pkg::OP_READ, 8'd0, 4'd0, 4'd0, 11'd3));
    send_request(make_request(tcw_pkg::OP_PUT, 8'd126, 4'h9, 4'h6, 11'd0));
    send_request(make_request(tcw_pkg::OP_READ, 8'd0, 4'd0, 4'd0, 11'(COLUMNS)));
    send_request(make_request(tcw_pkg::OP_CLEAR, 8'd0, 4'd0, 4'd0, 11'd0));
    send_request(make_request(tcw_pkg::OP_READ, 8'd0, 4'd0, 4'd0, 11'd0));
    send_request(make_request(tcw_pkg::OP_READ, 8'd0, 4'd0, 4'd0, 11'(CELLS - 1)));
    send_request(make_request(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE, 4'd0, 4'd0, 11'd0));
    send_request(make_request(tcw_pkg::OP_PUT, 8'd127, 4'h1, 4'he, 11'd0));

    for (int phase = 0; phase < 3; phase++) begin
      wait_results_drained();
      send_idle_pct = send_pct[phase];
      recv_idle_pct = recv_pct[phase];
      if (phase == 0) set_blank_colors(4'd15, 4'd0);
      else if (phase == 1) set_blank_colors(4'($urandom_range(15)), 4'($urandom_range(15)));
      else set_blank_colors(tcw_pkg::RESET_BLANK_FG, tcw_pkg::RESET_BLANK_BG);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // sender holds off now and then until the block has answered everything
        if (n == PHASE_ITEMS / 2 || $urandom_range(39) == 0) wait_results_drained();
        send_request(random_request());
      end
    end

    wait_results_drained();
    repeat (16) @(posedge clk);
    run_done = 1'b1;
    @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
